>>> rtl/core/sha256_message_hasher_defines.svh
// Assertion macros for the SHA-256 message hasher checker.
// No dependencies.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/core/sha_pkg.sv
// Package for the SHA-256 message hasher: payload types, constants, round functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // datapath commands from the controller
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUT_BYTE,
        CMD_LOAD_WORK,
        CMD_ROUND,
        CMD_ADD_CV,
        CMD_PAD_CLEAR,
        CMD_LENGTH,
        CMD_RESET_ALL
    } dp_cmd_e;

    typedef struct packed {
        dp_cmd_e    cmd;
        logic [5:0] round;
        logic [5:0] lane;
        logic [7:0] lane_value;
        logic       zero_rest;
        logic       count_inc;
    } dp_ctrl_t;

    typedef struct packed {
        logic [5:0] pos;
    } dp_stat_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] a);
        big_sigma0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] e);
        big_sigma1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] w);
        small_sigma0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] w);
        small_sigma1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
    endfunction
endpackage

>>> rtl/core/sha256_message_hasher.sv
// SHA-256 message hasher top level: byte stream in, eight digest words out.
// Intake: a byte that fills a block holds intake while the block is compressed (load, 64 rounds, add).
// The last byte adds one padded compression, or two, then 8 word transactions and the
// turnaround state. Other bytes are taken without leaving the idle state.
// Rate is set by the single shared round unit: one round per cycle.
// Reset: asynchronous active low; restores the initial hash and clears the count.
`timescale 1ns / 1ps
module sha256_message_hasher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sha_pkg::out_item_t  out_data
);
    sha_pkg::dp_ctrl_t ctrl;
    sha_pkg::dp_stat_t stat;
    logic [2:0]        rd_index;
    logic [31:0]       rd_word;

    // controller sequences byte intake, padding and the round counter
    sha_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .rd_index  (rd_index),
        .rd_word   (rd_word)
    );

    // datapath owns all hash state; digest word read straight from chaining value
    sha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .rd_index (rd_index),
        .rd_word  (rd_word)
    );
endmodule

>>> rtl/core/sha_datapath.sv
// SHA-256 datapath: block buffer as a 16-word schedule window, working
// registers, chaining value, byte counter. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::dp_ctrl_t  ctrl,
    output sha_pkg::dp_stat_t  stat,
    input  logic [2:0]         rd_index,
    output logic [31:0]        rd_word
);
    logic [31:0] w_reg [16];
    logic [31:0] work_reg [8];
    logic [31:0] cv_reg [8];
    logic [60:0] count_reg;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [31:0] maj;
    logic [31:0] ch;
    logic [63:0] bits;

    assign stat.pos = count_reg[5:0];
    assign rd_word  = cv_reg[rd_index];
    assign bits     = {count_reg, 3'b000};

    always_comb
    begin
        // window holds w[t..t+15]; w_reg[0] is w[t]
        w_new = sha_pkg::small_sigma1(w_reg[14]) + w_reg[9]
              + sha_pkg::small_sigma0(w_reg[1]) + w_reg[0];
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1 = work_reg[7] + sha_pkg::big_sigma1(work_reg[4]) + ch
           + sha_pkg::ROUND_K[ctrl.round] + w_reg[0];
        t2 = sha_pkg::big_sigma0(work_reg[0]) + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= sha_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            if (ctrl.count_inc)
            begin
                count_reg <= count_reg + 61'd1;
            end
            unique case (ctrl.cmd)
                sha_pkg::CMD_ADD_CV:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= cv_reg[i] + work_reg[i];
                    end
                end
                sha_pkg::CMD_RESET_ALL:
                begin
                    count_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= sha_pkg::INIT_HASH[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            sha_pkg::CMD_PUT_BYTE, sha_pkg::CMD_PAD_CLEAR:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if ((6'(i * 4 + b)) == ctrl.lane)
                        begin
                            w_reg[i][31 - b * 8 -: 8] <= ctrl.lane_value;
                        end
                        else if (ctrl.zero_rest && (6'(i * 4 + b) > ctrl.lane))
                        begin
                            w_reg[i][31 - b * 8 -: 8] <= 8'h00;
                        end
                    end
                end
            end
            sha_pkg::CMD_LENGTH:
            begin
                w_reg[14] <= bits[63:32];
                w_reg[15] <= bits[31:0];
            end
            sha_pkg::CMD_LOAD_WORK:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    work_reg[i] <= cv_reg[i];
                end
            end
            sha_pkg::CMD_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15]   <= w_new;
                work_reg[7] <= work_reg[6];
                work_reg[6] <= work_reg[5];
                work_reg[5] <= work_reg[4];
                work_reg[4] <= work_reg[3] + t1;
                work_reg[3] <= work_reg[2];
                work_reg[2] <= work_reg[1];
                work_reg[1] <= work_reg[0];
                work_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end
endmodule

>>> rtl/core/sha_controller.sv
// SHA-256 controller: byte intake, padding sequence, round counter, digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sha_pkg::out_item_t  out_data,
    output sha_pkg::dp_ctrl_t   ctrl,
    input  sha_pkg::dp_stat_t   stat,
    output logic [2:0]          rd_index,
    input  logic [31:0]         rd_word
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_PAD_LOAD,
        S_PAD_ROUND,
        S_PAD_ADD,
        S_LEN,
        S_EMIT,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [5:0]  round_reg;
    logic        last_reg;
    logic        final_reg;   // current compression is the length block
    logic [2:0]  idx_reg;
    logic        emit_reg;
    logic [5:0]  pos_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign rd_index  = idx_reg;
    assign out_valid = emit_reg;
    assign out_data.digest_word = rd_word;
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        ctrl = '{cmd: sha_pkg::CMD_NONE, round: round_reg, lane: stat.pos,
                 lane_value: in_data.data_byte, zero_rest: 1'b0, count_inc: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.cmd       = sha_pkg::CMD_PUT_BYTE;
                    ctrl.count_inc = 1'b1;
                end
            end
            S_LOAD, S_PAD_LOAD: ctrl.cmd = sha_pkg::CMD_LOAD_WORK;
            S_ROUND, S_PAD_ROUND: ctrl.cmd = sha_pkg::CMD_ROUND;
            S_ADD, S_PAD_ADD: ctrl.cmd = sha_pkg::CMD_ADD_CV;
            S_PAD:
            begin
                // extra length block carries no pad byte: all zero
                ctrl.cmd        = sha_pkg::CMD_PAD_CLEAR;
                ctrl.lane       = pos_reg;
                ctrl.lane_value = final_reg ? 8'h00 : 8'h80;
                ctrl.zero_rest  = 1'b1;
            end
            S_LEN:
            begin
                // write the message bit length into words 14 and 15 of the block
                ctrl.cmd = sha_pkg::CMD_LENGTH;
            end
            S_DONE: ctrl.cmd = sha_pkg::CMD_RESET_ALL;
            default: ctrl.cmd = sha_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
            emit_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= in_data.last_byte;
                        pos_reg  <= stat.pos + 6'd1;
                        if (stat.pos == 6'd63)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else if (in_data.last_byte)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    round_reg <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    state_reg <= last_reg ? S_PAD : S_IDLE;
                end
                S_PAD:
                begin
                    // pad byte and zeros; length fits only when pad lane < 56
                    final_reg <= (pos_reg < 6'd56);
                    state_reg <= (pos_reg < 6'd56) ? S_LEN : S_PAD_LOAD;
                end
                S_LEN:
                begin
                    final_reg <= 1'b1;
                    state_reg <= S_PAD_LOAD;
                end
                S_PAD_LOAD:
                begin
                    round_reg <= '0;
                    state_reg <= S_PAD_ROUND;
                end
                S_PAD_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_PAD_ADD;
                    end
                end
                S_PAD_ADD:
                begin
                    if (final_reg)
                    begin
                        idx_reg   <= '0;
                        emit_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        // next block: all zero then length
                        pos_reg   <= '0;
                        state_reg <= S_PAD;
                        final_reg <= 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (idx_reg == 3'd7)
                        begin
                            emit_reg  <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                S_DONE:
                begin
                    last_reg  <= 1'b0;
                    final_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/sha_checker.sv
// Port-level checker for the SHA-256 message hasher, bound to the top level.
// Depends on sha_pkg and sha256_message_hasher_defines.svh.
`timescale 1ns / 1ps
`include "sha256_message_hasher_defines.svh"
module sha_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input sha_pkg::out_item_t out_data
);
    // no intake while the digest is out
    `SHA_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // word index steps by one after each transaction
    `SHA_ASSERT_NEXT(a_idx_step, clk, rst_n, out_valid && out_ready && !out_data.last_word, out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1))
    // last flag only on word seven
    `SHA_ASSERT_IMPL(a_last_flag, clk, rst_n, out_valid, out_data.last_word == (out_data.word_index == 3'd7))
    // stalled output holds
    `SHA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind sha256_message_hasher sha_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
